/* rtl/audio_sample_mixer_formatter_core_macros.svh */
// Assertion macros for the RTL.
// Compiled out when SYNTHESIS is defined.
`ifndef AUDIO_SAMPLE_MIXER_FORMATTER_CORE_MACROS_SVH
`define AUDIO_SAMPLE_MIXER_FORMATTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ASMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/asmf_pkg.sv */
`default_nettype none
package asmf_pkg;

    // config port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 28;
    localparam int BUF_BYTES_W = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_FORWARD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_VOLUME   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_VOLUME  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MODE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_SAMPLES  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_BYTES  = 3'd6;

    localparam logic [27:0] RST_SAMPLE_PERIOD = 28'd8060928;
    localparam logic [13:0] RST_FAST_FORWARD  = 14'd256;
    localparam logic [7:0]  RST_LEFT_VOLUME   = 8'd255;
    localparam logic [7:0]  RST_RIGHT_VOLUME  = 8'd255;
    localparam logic [2:0]  RST_CHANNEL_MODE  = 3'd0;
    localparam logic        RST_WIDE_SAMPLES  = 1'b1;
    localparam logic [16:0] RST_BUFFER_BYTES  = 17'd4096;

    // channel modes
    localparam logic [2:0] MODE_MONO_LEFT  = 3'd0;
    localparam logic [2:0] MODE_MONO_MIX   = 3'd1;
    localparam logic [2:0] MODE_MONO_RIGHT = 3'd2;
    localparam logic [2:0] MODE_STEREO_DUP = 3'd3;
    localparam logic [2:0] MODE_STEREO     = 3'd4;

    // commands
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_MIX     = 1'b1;

    // divide by 255: floor(2^23/255), estimate is low by at most one
    localparam int          MAG_W       = 23;
    localparam int          RECIP_W     = 16;
    localparam int          RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP_255 = 16'd32896;
    localparam logic [23:0] VOL_UNITY   = 24'd255;

    localparam logic [16:0] DELAY_MAX   = 17'h1FFFF;
    localparam logic [7:0]  OFFSET_BIN  = 8'h80;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_in_word;

    typedef struct packed {
        logic [16:0] delay_cycles;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last;
        logic        buffer_full;
    } t_out_word;

    typedef struct packed {
        logic        cmd;
        logic [16:0] delay;
    } t_stage_info;

    typedef struct packed {
        logic [2:0]             channel_mode;
        logic                   wide_samples;
        logic [BUF_BYTES_W-1:0] buffer_bytes;
    } t_fmt_cfg;

endpackage
`default_nettype wire

/* rtl/asmf_lane.sv */
`default_nettype none
// Signed divide by 255 (or 510 with i_halve), truncating toward zero.
// Two register stages: magnitude, then reciprocal product.
module asmf_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [24:0] i_dividend,
    input  logic               i_halve,
    output logic [15:0]        o_quot
);

    localparam int PROD_W = asmf_pkg::MAG_W + asmf_pkg::RECIP_W;

    logic [24:0]                  w_abs;
    logic [asmf_pkg::MAG_W-1:0]   w_mag;
    logic                         r_neg_a;
    logic [asmf_pkg::MAG_W-1:0]   r_mag_a;
    logic                         r_neg_b;
    logic [asmf_pkg::MAG_W-1:0]   r_mag_b;
    logic [PROD_W-1:0]            r_prod;
    logic [15:0]                  w_q_est;
    logic [23:0]                  w_back;
    logic [23:0]                  w_rem;
    logic [15:0]                  w_q;

    always_comb begin
        w_abs = i_dividend[24] ? $unsigned(-i_dividend) : $unsigned(i_dividend);
        // |x| <= 2*32768*255 when halved and 32768*255 otherwise, so either form fits the magnitude width
        w_mag = i_halve ? w_abs[asmf_pkg::MAG_W:1] : w_abs[asmf_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_dividend[24];
            r_mag_a <= w_mag;
            r_neg_b <= r_neg_a;
            r_mag_b <= r_mag_a;
            r_prod  <= PROD_W'(r_mag_a) * PROD_W'(asmf_pkg::RECIP_255);
        end
    end

    always_comb begin
        w_q_est = r_prod[asmf_pkg::RECIP_SHIFT +: 16];
        w_back  = {w_q_est, 8'd0} - {8'd0, w_q_est};
        w_rem   = {1'b0, r_mag_b} - w_back;
        w_q     = (w_rem >= asmf_pkg::VOL_UNITY) ? (w_q_est + 16'd1) : w_q_est;
        o_quot  = r_neg_b ? (16'd0 - w_q) : w_q;
    end

endmodule
`default_nettype wire

/* rtl/asmf_merge.sv */
`default_nettype none
`include "audio_sample_mixer_formatter_core_macros.svh"
// Picks lane results by channel mode, formats the frame, keeps the byte
// count, and plays the frame out one word per cycle while not stalled.
module asmf_merge #(
    parameter int BYTE_COUNT_BITS = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  asmf_pkg::t_stage_info i_info,
    input  logic [15:0]           i_left,
    input  logic [15:0]           i_right,
    input  logic [15:0]           i_mix,
    input  asmf_pkg::t_fmt_cfg    i_cfg,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output asmf_pkg::t_out_word   o_out_word,
    output logic                  o_free
);

    localparam int SUM_W = BYTE_COUNT_BITS + 1;
    localparam int CMP_W = (BYTE_COUNT_BITS > asmf_pkg::BUF_BYTES_W) ?
                           BYTE_COUNT_BITS : asmf_pkg::BUF_BYTES_W;

    logic                       r_fv;
    logic [2:0]                 r_rem;
    logic [7:0]                 r_bytes [4];
    logic [16:0]                r_delay;
    logic                       r_byte_valid;
    logic                       r_full_out;
    logic [BYTE_COUNT_BITS-1:0] r_bc;
    logic                       r_full;

    logic [15:0]                w_v0;
    logic [15:0]                w_v1;
    logic                       w_two;
    logic [2:0]                 w_nbytes;
    logic [7:0]                 w_fb [4];
    logic [SUM_W-1:0]           w_sum_bc;
    logic [BYTE_COUNT_BITS-1:0] n_bc;
    logic                       w_reach;
    logic                       w_last;
    logic                       w_take;

    always_comb begin
        w_v0  = i_left;
        w_v1  = i_left;
        w_two = 1'b0;
        unique case (i_cfg.channel_mode)
            asmf_pkg::MODE_MONO_MIX:   w_v0 = i_mix;
            asmf_pkg::MODE_MONO_RIGHT: w_v0 = i_right;
            asmf_pkg::MODE_STEREO_DUP: w_two = 1'b1;
            asmf_pkg::MODE_STEREO: begin
                w_v1  = i_right;
                w_two = 1'b1;
            end
            default: w_v0 = i_left;
        endcase

        if (i_cfg.wide_samples) begin
            w_fb[0]  = w_v0[7:0];
            w_fb[1]  = w_v0[15:8];
            w_fb[2]  = w_v1[7:0];
            w_fb[3]  = w_v1[15:8];
            w_nbytes = w_two ? 3'd4 : 3'd2;
        end else begin
            w_fb[0]  = w_v0[7:0] ^ asmf_pkg::OFFSET_BIN;
            w_fb[1]  = w_v1[7:0] ^ asmf_pkg::OFFSET_BIN;
            w_fb[2]  = 8'd0;
            w_fb[3]  = 8'd0;
            w_nbytes = w_two ? 3'd2 : 3'd1;
        end

        // saturating byte count
        w_sum_bc = {1'b0, r_bc} + SUM_W'(w_nbytes);
        n_bc     = w_sum_bc[BYTE_COUNT_BITS] ? '1 : w_sum_bc[BYTE_COUNT_BITS-1:0];
        w_reach  = CMP_W'(n_bc) >= CMP_W'(i_cfg.buffer_bytes);
    end

    assign w_last = (r_rem == 3'd1);
    assign w_take = r_fv && !i_out_stall;
    assign o_free = !r_fv || (w_take && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv   <= 1'b0;
            r_rem  <= 3'd0;
            r_bc   <= '0;
            r_full <= 1'b0;
        end else if (i_load) begin
            r_fv <= 1'b1;
            if (i_info.cmd == asmf_pkg::CMD_RESTART) begin
                r_rem  <= 3'd1;
                r_bc   <= '0;
                r_full <= 1'b0;
            end else begin
                r_rem <= w_nbytes;
                if (!r_full) begin
                    r_bc   <= n_bc;
                    r_full <= w_reach;
                end
            end
        end else if (w_take) begin
            if (w_last) begin
                r_fv <= 1'b0;
            end
            r_rem <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_delay <= i_info.delay;
            if (i_info.cmd == asmf_pkg::CMD_RESTART) begin
                r_bytes[0]   <= 8'd0;
                r_byte_valid <= 1'b0;
                r_full_out   <= 1'b0;
            end else begin
                r_bytes      <= w_fb;
                r_byte_valid <= 1'b1;
                r_full_out   <= r_full || w_reach;
            end
        end else if (w_take) begin
            r_bytes[0] <= r_bytes[1];
            r_bytes[1] <= r_bytes[2];
            r_bytes[2] <= r_bytes[3];
        end
    end

    assign o_out_valid            = r_fv;
    assign o_out_word.delay_cycles = r_delay;
    assign o_out_word.data_byte    = r_bytes[0];
    assign o_out_word.byte_valid   = r_byte_valid;
    assign o_out_word.last         = w_last;
    assign o_out_word.buffer_full  = r_full_out;

    `ASMF_ASSERT_IMPLY(a_rem_range, i_clk, i_rst_n, r_fv, (r_rem != 3'd0) && (r_rem <= 3'd4), "frame count out of range")
    `ASMF_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, i_load, !r_fv || (w_take && w_last), "frame overwritten before last word left")
    `ASMF_ASSERT_IMPLY(a_restart_word, i_clk, i_rst_n, r_fv && !r_byte_valid, w_last && !r_full_out, "restart word malformed")
    `ASMF_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, i_load && (i_info.cmd == asmf_pkg::CMD_RESTART), (r_bc == '0) && !r_full, "restart did not clear byte count")

endmodule
`default_nettype wire

/* rtl/audio_sample_mixer_formatter_core.sv */
`default_nettype none
// Audio mixer/formatter. Each input word either restarts the sample clock
// (one result word, byte_valid low) or mixes one left/right sample pair into
// a frame of 1, 2 or 4 bytes, sent one byte per output word with the delay
// to the next sample event and the buffer-full flag on every word. Results
// pass the stage 1, 2 and 3 registers and the frame register; from there
// the block delivers one output word per cycle unless i_out_stall is high.
// Input words are taken while the previous frame is still being sent;
// input stall rises only when a finished frame waits behind one still in
// the output register. Configuration registers are written through a
// separate valid/ready port that is always ready; write them only while
// no item is in flight.
module audio_sample_mixer_formatter_core #(
    parameter int BYTE_COUNT_BITS = 17
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    input  asmf_pkg::t_in_word                i_in_word,
    output logic                              o_in_stall,
    // result words
    output logic                              o_out_valid,
    output asmf_pkg::t_out_word               o_out_word,
    input  logic                              i_out_stall,
    // configuration writes
    input  logic                              i_cfg_valid,
    input  logic [asmf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [asmf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_cfg_ready
);

    // configuration registers
    logic [27:0] r_sample_period;
    logic [13:0] r_fast_forward;
    logic [7:0]  r_left_volume;
    logic [7:0]  r_right_volume;
    logic [2:0]  r_channel_mode;
    logic        r_wide_samples;
    logic [16:0] r_buffer_bytes;

    // pipeline: stage 1 products, stage 2/3 lane divide, then frame register
    logic               w_en;
    logic               w_frame_free;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r1_cmd;
    logic signed [24:0] r1_lp;
    logic signed [24:0] r1_rp;
    logic [41:0]        r1_cprod;
    logic               r2_cmd;
    logic [16:0]        r2_delay;
    logic               r3_cmd;
    logic [16:0]        r3_delay;
    logic [15:0]        r_frac;

    logic signed [24:0] n_lp;
    logic signed [24:0] n_rp;
    logic [41:0]        n_cprod;
    logic [34:0]        w_sum;
    logic [16:0]        n_delay;
    logic [15:0]        n_frac;
    logic signed [24:0] w_mix_sum;

    logic [15:0]           w_left_q;
    logic [15:0]           w_right_q;
    logic [15:0]           w_mix_q;
    asmf_pkg::t_stage_info w_info;
    asmf_pkg::t_fmt_cfg    w_fmt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= asmf_pkg::RST_SAMPLE_PERIOD;
            r_fast_forward  <= asmf_pkg::RST_FAST_FORWARD;
            r_left_volume   <= asmf_pkg::RST_LEFT_VOLUME;
            r_right_volume  <= asmf_pkg::RST_RIGHT_VOLUME;
            r_channel_mode  <= asmf_pkg::RST_CHANNEL_MODE;
            r_wide_samples  <= asmf_pkg::RST_WIDE_SAMPLES;
            r_buffer_bytes  <= asmf_pkg::RST_BUFFER_BYTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                asmf_pkg::REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[27:0];
                asmf_pkg::REG_FAST_FORWARD:  r_fast_forward  <= i_cfg_data[13:0];
                asmf_pkg::REG_LEFT_VOLUME:   r_left_volume   <= i_cfg_data[7:0];
                asmf_pkg::REG_RIGHT_VOLUME:  r_right_volume  <= i_cfg_data[7:0];
                asmf_pkg::REG_CHANNEL_MODE:  r_channel_mode  <= i_cfg_data[2:0];
                asmf_pkg::REG_WIDE_SAMPLES:  r_wide_samples  <= i_cfg_data[0];
                asmf_pkg::REG_BUFFER_BYTES:  r_buffer_bytes  <= i_cfg_data[16:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // whole pipe moves together; it holds only when stage 3 has a frame
    // ready and the output register is still busy
    assign w_en       = !r_v3 || w_frame_free;
    assign o_in_stall = !w_en;

    // stage 1: voice gains and the clock step product
    always_comb begin
        n_lp    = 25'(i_in_word.left_sample) * 25'($signed({1'b0, r_left_volume}));
        n_rp    = 25'(i_in_word.right_sample) * 25'($signed({1'b0, r_right_volume}));
        n_cprod = 42'(r_sample_period) * 42'(r_fast_forward);
    end

    // stage 2: advance the fractional sample clock (Q.16)
    always_comb begin
        w_sum = 35'(r_frac) + 35'(r1_cprod[41:8]);
        if (r1_cmd == asmf_pkg::CMD_RESTART) begin
            n_delay = {5'd0, r_sample_period[27:16]};
            n_frac  = r_sample_period[15:0];
        end else begin
            n_delay = (|w_sum[34:33]) ? asmf_pkg::DELAY_MAX : w_sum[32:16];
            n_frac  = w_sum[15:0];
        end
        w_mix_sum = r1_lp + r1_rp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_frac <= 16'd0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v1) begin
                r_frac <= n_frac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd   <= i_in_word.cmd;
            r1_lp    <= n_lp;
            r1_rp    <= n_rp;
            r1_cprod <= n_cprod;
            r2_cmd   <= r1_cmd;
            r2_delay <= n_delay;
            r3_cmd   <= r2_cmd;
            r3_delay <= r2_delay;
        end
    end

    // three divider lanes: left/255, right/255, (left+right)/510
    asmf_lane u_lane_left (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r1_lp),
        .i_halve    (1'b0),
        .o_quot     (w_left_q)
    );

    asmf_lane u_lane_right (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r1_rp),
        .i_halve    (1'b0),
        .o_quot     (w_right_q)
    );

    asmf_lane u_lane_mix (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (w_mix_sum),
        .i_halve    (1'b1),
        .o_quot     (w_mix_q)
    );

    assign w_info.cmd         = r3_cmd;
    assign w_info.delay       = r3_delay;
    assign w_fmt.channel_mode = r_channel_mode;
    assign w_fmt.wide_samples = r_wide_samples;
    assign w_fmt.buffer_bytes = r_buffer_bytes;

    // mode select, byte formatting, byte count and output register
    asmf_merge #(
        .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_en && r_v3),
        .i_info      (w_info),
        .i_left      (w_left_q),
        .i_right     (w_right_q),
        .i_mix       (w_mix_q),
        .i_cfg       (w_fmt),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_free      (w_frame_free)
    );

endmodule
`default_nettype wire
